// ===== sv/rusi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rusi_pkg;
	localparam int CoordWidth = 32;
	localparam int FracBits = 16;
	localparam int TWidth = 31;
	localparam int PtWidth = 18;
endpackage
`default_nettype wire

// ===== sv/rusi_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Pipelined floor square root: one result bit per stage.
module rusi_sqrt import rusi_pkg::*; #(
	parameter int W = 200,
	parameter int SW = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          vin,
	input  wire logic [W-1:0]  rad,
	input  wire logic [SW-1:0] side,
	output logic               vout,
	output logic [W/2-1:0]     root,
	output logic [SW-1:0]      side_out
);
	localparam int N = W / 2;
	logic [N:0]     v_s;
	logic [W-1:0]   rem_s [N+1];
	logic [N-1:0]   res_s [N+1];
	logic [W-1:0]   rad_s [N+1];
	logic [SW-1:0]  sd_s  [N+1];

	assign v_s[0] = vin;
	assign rem_s[0] = '0;
	assign res_s[0] = '0;
	assign rad_s[0] = rad;
	assign sd_s[0] = side;

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic [W-1:0] rem_sh;
		logic [W-1:0] trial;
		logic         ge;
		assign rem_sh = {rem_s[i][W-3:0], rad_s[i][W-1 -: 2]};
		assign trial = {{(W-N-2){1'b0}}, res_s[i], 2'b01};
		assign ge = rem_sh >= trial;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end
		always_ff @(posedge clk) begin
			rem_s[i+1] <= ge ? rem_sh - trial : rem_sh;
			res_s[i+1] <= {res_s[i][N-2:0], ge};
			rad_s[i+1] <= {rad_s[i][W-3:0], 2'b00};
			sd_s[i+1] <= sd_s[i];
		end
	end

	assign vout = v_s[N];
	assign root = res_s[N];
	assign side_out = sd_s[N];
endmodule
`default_nettype wire

// ===== sv/rusi_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage, with a remainder flag.
module rusi_div import rusi_pkg::*; #(
	parameter int NW = 100,
	parameter int DW = 100
) (
	input  wire logic          clk,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic [NW-1:0]      quo,
	output logic               inexact
);
	logic [DW:0]    rem_s [NW+1];
	logic [NW-1:0]  q_s   [NW+1];
	logic [NW-1:0]  n_s   [NW+1];
	logic [DW-1:0]  d_s   [NW+1];

	assign rem_s[0] = '0;
	assign q_s[0] = '0;
	assign n_s[0] = num;
	assign d_s[0] = den;

	for (genvar i = 0; i < NW; i++) begin : g_stage
		logic [DW+1:0] sh;
		logic          ge;
		assign sh = {rem_s[i], n_s[i][NW-1]};
		assign ge = sh >= {2'b00, d_s[i]};
		always_ff @(posedge clk) begin
			rem_s[i+1] <= ge ? (DW+1)'(sh - {2'b00, d_s[i]}) : sh[DW:0];
			q_s[i+1] <= {q_s[i][NW-2:0], ge};
			n_s[i+1] <= {n_s[i][NW-2:0], 1'b0};
			d_s[i+1] <= d_s[i];
		end
	end

	assign quo = q_s[NW];
	assign inexact = rem_s[NW] != '0;
endmodule
`default_nettype wire

// ===== sv/ray_unit_sphere_intersect_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Fully pipelined: one request can be accepted every cycle and busy is always low.
// The result is strobed by done after passing through the square root (2*CW + 3 stages)
// and divider (3*CW + 2 stages) pipelines plus ten register stages; the receiver cannot
// stall.
// Every request yields exactly one result, strobed by done for one cycle.
// Reset clears only the valid bits of the pipeline.
module ray_unit_sphere_intersect_core import rusi_pkg::*; #(
	parameter int COORD_WIDTH = CoordWidth,
	parameter int FRAC_BITS = FracBits
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic signed [COORD_WIDTH-1:0] origin_x,
	input  wire logic signed [COORD_WIDTH-1:0] origin_y,
	input  wire logic signed [COORD_WIDTH-1:0] origin_z,
	input  wire logic signed [COORD_WIDTH-1:0] dir_x,
	input  wire logic signed [COORD_WIDTH-1:0] dir_y,
	input  wire logic signed [COORD_WIDTH-1:0] dir_z,
	output logic                               done,
	output logic                               hit,
	output logic [TWidth-1:0]                  t_near,
	output logic signed [PtWidth-1:0]          point_x,
	output logic signed [PtWidth-1:0]          point_y,
	output logic signed [PtWidth-1:0]          point_z
);
	localparam int CW = COORD_WIDTH;
	localparam int PW = 2 * CW + 2;      // dot products
	localparam int H = PW / 2;           // half of a dot product
	localparam int QW = 4 * CW + 6;      // discriminant
	localparam int RW = QW / 2;          // root
	localparam int DNW = RW + 1;         // denominator
	localparam int CDW = PW + CW;        // C * D and numerators

	logic signed [CW-1:0] o_s1 [3];
	logic signed [CW-1:0] d_s1 [3];
	logic                 v_s1;
	logic signed [2*CW-1:0] oo_s2 [3];
	logic signed [2*CW-1:0] dd_s2 [3];
	logic signed [2*CW-1:0] od_s2 [3];
	logic signed [CW-1:0] o_s2 [3];
	logic signed [CW-1:0] d_s2 [3];
	logic                 v_s2;
	logic signed [PW-1:0] c_s3;
	logic signed [PW-1:0] dd_s3;
	logic signed [PW-1:0] p_s3;
	logic signed [CW-1:0] o_s3 [3];
	logic signed [CW-1:0] d_s3 [3];
	logic                 v_s3;
	logic signed [H-1:0]  ph3;
	logic signed [H:0]    pl3;
	logic signed [H-1:0]  ddh3;
	logic signed [H:0]    ddl3;
	logic signed [H-1:0]  ch3;
	logic signed [H:0]    cl3;
	logic signed [2*H-1:0] pp_hh_s4;
	logic signed [2*H:0]   pp_hl_s4;
	logic [2*H-1:0]        pp_ll_s4;
	logic signed [2*H-1:0] dc_hh_s4;
	logic signed [2*H:0]   dc_hl_s4;
	logic signed [2*H:0]   dc_lh_s4;
	logic [2*H-1:0]        dc_ll_s4;
	logic signed [PW-1:0] c_s4;
	logic signed [PW-1:0] p_s4;
	logic signed [CW-1:0] o_s4 [3];
	logic signed [CW-1:0] d_s4 [3];
	logic                 v_s4;
	logic signed [QW-1:0] pp_s5;
	logic signed [QW-1:0] dc_s5;
	logic                 ok_s5;
	logic signed [PW-1:0] c_s5;
	logic signed [PW-1:0] p_s5;
	logic signed [CW-1:0] o_s5 [3];
	logic signed [CW-1:0] d_s5 [3];
	logic                 v_s5;
	logic signed [QW-1:0] q_s6;
	logic                 ok_s6;
	logic signed [PW-1:0] c_s6;
	logic signed [PW-1:0] p_s6;
	logic signed [CW-1:0] o_s6 [3];
	logic signed [CW-1:0] d_s6 [3];
	logic                 v_s6;

	assign busy = 1'b0;

	assign ph3 = p_s3[PW-1:H];
	assign pl3 = {1'b0, p_s3[H-1:0]};
	assign ddh3 = dd_s3[PW-1:H];
	assign ddl3 = {1'b0, dd_s3[H-1:0]};
	assign ch3 = c_s3[PW-1:H];
	assign cl3 = {1'b0, c_s3[H-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		o_s1[0] <= origin_x;
		o_s1[1] <= origin_y;
		o_s1[2] <= origin_z;
		d_s1[0] <= dir_x;
		d_s1[1] <= dir_y;
		d_s1[2] <= dir_z;
		for (int k = 0; k < 3; k++) begin
			oo_s2[k] <= o_s1[k] * o_s1[k];
			dd_s2[k] <= d_s1[k] * d_s1[k];
			od_s2[k] <= o_s1[k] * d_s1[k];
		end
		o_s2 <= o_s1;
		d_s2 <= d_s1;
		c_s3 <= PW'(oo_s2[0]) + PW'(oo_s2[1]) + PW'(oo_s2[2])
			- (PW'(1) << (2 * FRAC_BITS));
		dd_s3 <= PW'(dd_s2[0]) + PW'(dd_s2[1]) + PW'(dd_s2[2]);
		p_s3 <= PW'(od_s2[0]) + PW'(od_s2[1]) + PW'(od_s2[2]);
		o_s3 <= o_s2;
		d_s3 <= d_s2;
		pp_hh_s4 <= ph3 * ph3;
		pp_hl_s4 <= ph3 * pl3;
		pp_ll_s4 <= p_s3[H-1:0] * p_s3[H-1:0];
		dc_hh_s4 <= ddh3 * ch3;
		dc_hl_s4 <= ddh3 * cl3;
		dc_lh_s4 <= ddl3 * ch3;
		dc_ll_s4 <= dd_s3[H-1:0] * c_s3[H-1:0];
		c_s4 <= c_s3;
		p_s4 <= p_s3;
		o_s4 <= o_s3;
		d_s4 <= d_s3;
		pp_s5 <= (QW'(pp_hh_s4) << (2 * H)) + (QW'(pp_hl_s4) << (H + 1))
			+ QW'(pp_ll_s4);
		dc_s5 <= (QW'(dc_hh_s4) << (2 * H)) + (QW'(dc_hl_s4) << H)
			+ (QW'(dc_lh_s4) << H) + QW'(dc_ll_s4);
		ok_s5 <= !c_s4[PW-1] && (p_s4[PW-1] || p_s4 == '0);
		c_s5 <= c_s4;
		p_s5 <= p_s4;
		o_s5 <= o_s4;
		d_s5 <= d_s4;
		q_s6 <= pp_s5 - dc_s5;
		ok_s6 <= ok_s5;
		c_s6 <= c_s5;
		p_s6 <= p_s5;
		o_s6 <= o_s5;
		d_s6 <= d_s5;
	end

	typedef struct packed {
		logic                 ok;
		logic signed [PW-1:0] c;
		logic signed [PW-1:0] p;
		logic signed [CW-1:0] ox;
		logic signed [CW-1:0] oy;
		logic signed [CW-1:0] oz;
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		logic signed [CW-1:0] dz;
	} side_t;

	side_t           sd_in;
	side_t           sd_out;
	logic            v_sq;
	logic [RW-1:0]   root;

	assign sd_in = '{ok: ok_s6 && !q_s6[QW-1] && q_s6 != '0, c: c_s6, p: p_s6,
		ox: o_s6[0], oy: o_s6[1], oz: o_s6[2], dx: d_s6[0], dy: d_s6[1], dz: d_s6[2]};

	rusi_sqrt #(.W(QW), .SW($bits(side_t))) u_sqrt (
		.clk(clk), .arst_n(arst_n), .vin(v_s6), .rad(q_s6), .side(sd_in),
		.vout(v_sq), .root(root), .side_out(sd_out)
	);

	// On a hit C is non-negative, so the sign of C * D is that of D.
	logic [DNW-1:0]      den_s7;
	logic [CDW-1:0]      tn_s7;
	logic [H+CW-1:0]     cdh_s7 [3];
	logic [H+CW-1:0]     cdl_s7 [3];
	logic [2:0]          neg_s7;
	side_t               sd_s7;
	logic                v_s7;
	logic [CDW-1:0]      mag_s8 [3];
	logic [2:0]          neg_s8;
	logic [CDW-1:0]      tn_s8;
	logic [DNW-1:0]      den_s8;
	side_t               sd_s8;
	logic                v_s8;
	logic signed [CW-1:0] dsel [3];
	logic [CW-1:0]       dabs [3];

	assign dsel[0] = sd_out.dx;
	assign dsel[1] = sd_out.dy;
	assign dsel[2] = sd_out.dz;
	for (genvar k = 0; k < 3; k++) begin : g_dabs
		assign dabs[k] = dsel[k][CW-1] ? CW'(-dsel[k]) : dsel[k];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			v_s7 <= v_sq;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		den_s7 <= DNW'({1'b0, root}) - DNW'(sd_out.p);
		tn_s7 <= CDW'(sd_out.c) << FRAC_BITS;
		for (int k = 0; k < 3; k++) begin
			cdh_s7[k] <= sd_out.c[PW-1:H] * dabs[k];
			cdl_s7[k] <= sd_out.c[H-1:0] * dabs[k];
			neg_s7[k] <= dsel[k][CW-1];
		end
		sd_s7 <= sd_out;
		for (int k = 0; k < 3; k++) begin
			mag_s8[k] <= (CDW'(cdh_s7[k]) << H) + CDW'(cdl_s7[k]);
		end
		neg_s8 <= neg_s7;
		tn_s8 <= tn_s7;
		den_s8 <= den_s7;
		sd_s8 <= sd_s7;
	end

	localparam int DL = CDW;
	logic [CDW-1:0] tq;
	logic           t_inx;
	logic [CDW-1:0] pq [3];
	logic [2:0]     p_inx;

	rusi_div #(.NW(CDW), .DW(DNW)) u_div_t (
		.clk(clk), .num(tn_s8), .den(den_s8), .quo(tq), .inexact(t_inx)
	);
	for (genvar k = 0; k < 3; k++) begin : g_pdiv
		rusi_div #(.NW(CDW), .DW(DNW)) u_div_p (
			.clk(clk), .num(mag_s8[k]), .den(den_s8), .quo(pq[k]), .inexact(p_inx[k])
		);
	end

	// Delay line for the side data alongside the dividers.
	logic [DL:0] v_dl;
	side_t       sd_dl [DL+1];
	logic [2:0]  ng_dl [DL+1];
	assign v_dl[0] = v_s8;
	assign sd_dl[0] = sd_s8;
	assign ng_dl[0] = neg_s8;
	for (genvar i = 0; i < DL; i++) begin : g_dl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_dl[i+1] <= 1'b0;
			end else begin
				v_dl[i+1] <= v_dl[i];
			end
		end
		always_ff @(posedge clk) begin
			sd_dl[i+1] <= sd_dl[i];
			ng_dl[i+1] <= ng_dl[i];
		end
	end

	side_t                 sdf;
	logic signed [CDW+1:0] pt_s9 [3];
	logic [TWidth-1:0]     t_s9;
	logic                  ok_s9;
	logic                  v_s9;
	logic signed [CW-1:0]  osel [3];
	localparam logic signed [CDW+1:0] Unit = (CDW+2)'(1) << FRAC_BITS;

	assign sdf = sd_dl[DL];
	assign osel[0] = sdf.ox;
	assign osel[1] = sdf.oy;
	assign osel[2] = sdf.oz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s9 <= v_dl[DL];
			done <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		ok_s9 <= sdf.ok;
		t_s9 <= (tq > CDW'({TWidth{1'b1}})) ? {TWidth{1'b1}} : TWidth'(tq);
		for (int k = 0; k < 3; k++) begin
			pt_s9[k] <= (CDW+2)'(osel[k]) + (ng_dl[DL][k]
				? -((CDW+2)'(pq[k]) + (CDW+2)'(p_inx[k]))
				: (CDW+2)'(pq[k]));
		end
		hit <= ok_s9;
		t_near <= ok_s9 ? t_s9 : '0;
		point_x <= !ok_s9 ? '0 : pt_s9[0] > Unit ? PtWidth'(Unit)
			: pt_s9[0] < -Unit ? PtWidth'(-Unit) : PtWidth'(pt_s9[0]);
		point_y <= !ok_s9 ? '0 : pt_s9[1] > Unit ? PtWidth'(Unit)
			: pt_s9[1] < -Unit ? PtWidth'(-Unit) : PtWidth'(pt_s9[1]);
		point_z <= !ok_s9 ? '0 : pt_s9[2] > Unit ? PtWidth'(Unit)
			: pt_s9[2] < -Unit ? PtWidth'(-Unit) : PtWidth'(pt_s9[2]);
	end

	assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	assert property (@(posedge clk) disable iff (!arst_n) done && !hit |-> t_near == '0)
		else $error("miss with non-zero distance");
	assert property (@(posedge clk) disable iff (!arst_n) v_s7 && sd_s7.ok |-> den_s7 != '0)
		else $error("zero denominator on a hit");
endmodule
`default_nettype wire
